// ===== rtl/bbcra_pkg.sv =====
// Package: types, request codes and controller states for the buffer cache.
package bbcra_pkg;

  localparam int TAG_W = 16;
  localparam int IDX_W = 3;
  localparam int CNT_W = 2;

  typedef enum logic [1:0] {
    FUNC_BREADA  = 2'd0,
    FUNC_BREAD   = 2'd1,
    FUNC_BRELSE  = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE_A,
    ST_TAKE_B,
    ST_TAKE_A2,
    ST_RELEASE,
    ST_DONE
  } state_t;

  // Which operation a step performs: none, take block a, take block b or release.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_TAKE_A,
    OP_TAKE_B,
    OP_RELEASE
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
    logic set_valid;
    logic fin_a;
  } cmd_t;

  typedef struct packed {
    logic cached_a;
    logic match_b;
    logic ok;
    logic failed;
  } stat_t;

endpackage

// ===== rtl/bbcra_ctrl.sv =====
// Controller: sequences the take and release steps of one request.
module bbcra_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_go,
  input  bbcra_pkg::func_t func,
  input  bbcra_pkg::stat_t st,
  input  logic             out_free,
  output logic             busy,
  output logic             done,
  output bbcra_pkg::cmd_t  cmd
);
  import bbcra_pkg::*;

  state_t state, state_next;
  logic   cached, cached_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cached <= 1'b0;
    end else begin
      state  <= state_next;
      cached <= cached_next;
    end
  end

  always_comb begin
    state_next  = state;
    cached_next = cached;
    case (state)
      ST_IDLE: begin
        if (in_go) begin
          case (func)
            FUNC_BREADA: begin
              cached_next = st.cached_a;
              state_next  = st.cached_a ? ST_TAKE_B : ST_TAKE_A;
            end
            FUNC_BREAD:  state_next = ST_TAKE_A2;
            FUNC_BRELSE: state_next = ST_RELEASE;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_TAKE_A:  state_next = st.ok ? ST_TAKE_B : ST_DONE;
      ST_TAKE_B:  state_next = cached ? ST_TAKE_A2 : ST_DONE;
      ST_TAKE_A2: state_next = ST_DONE;
      ST_RELEASE: state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    busy      = (state != ST_IDLE);
    done      = (state == ST_DONE) && out_free;
    cmd.start = (state == ST_IDLE) && in_go;
    case (state)
      ST_TAKE_A:  cmd.op = OP_TAKE_A;
      ST_TAKE_B:  begin
        cmd.op        = OP_TAKE_B;
        cmd.set_valid = 1'b1;
      end
      ST_TAKE_A2: begin
        cmd.op    = OP_TAKE_A;
        cmd.fin_a = 1'b1;
      end
      ST_RELEASE: cmd.op = OP_RELEASE;
      default:    cmd.op = OP_NONE;
    endcase
  end
endmodule

// ===== rtl/bbcra_dp.sv =====
// Datapath: entry table, free stack, tag search and result fields.
module bbcra_dp #(
  parameter int NUM_BUFFERS = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bbcra_pkg::TAG_W-1:0] in_a,
  input  logic [bbcra_pkg::TAG_W-1:0] in_b,
  input  logic [bbcra_pkg::IDX_W-1:0] in_rel,
  input  bbcra_pkg::cmd_t            cmd,
  output bbcra_pkg::stat_t           st,
  output logic [15:0]                res
);
  import bbcra_pkg::*;

  localparam int NW = $clog2(NUM_BUFFERS + 1);
  localparam int EW = $clog2(NUM_BUFFERS);

  logic [TAG_W-1:0] tag [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] ebusy, evalid, edly;
  logic [EW-1:0] order [NUM_BUFFERS];
  logic [NW-1:0] fcount;

  logic [TAG_W-1:0] blk_a, blk_b;
  logic [IDX_W-1:0] rel;
  logic status, hit, rd, ahead;
  logic [CNT_W-1:0] waits, flushes;
  logic [IDX_W-1:0] idx;

  // Search: lowest matching index for the current key.
  logic [TAG_W-1:0] key;
  logic             m_hit, mb_hit, ma_hit;
  logic [EW-1:0]    m_idx;
  logic [NUM_BUFFERS-1:0] onlist;
  logic [EW-1:0]    sel;
  logic             can;

  always_comb begin
    key   = (cmd.op == OP_TAKE_B) ? blk_b : blk_a;
    m_hit = 1'b0; m_idx = '0; mb_hit = 1'b0; ma_hit = 1'b0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (tag[i] == key) begin
        m_hit = 1'b1;
        m_idx = EW'(i);
      end
      if (tag[i] == blk_b) mb_hit = 1'b1;
      if (tag[i] == in_a)  ma_hit = 1'b1;
    end
    onlist = '0;
    for (int k = 0; k < NUM_BUFFERS; k++)
      if (NW'(k) < fcount) onlist[order[k]] = 1'b1;
    sel = m_hit ? m_idx : order[0];
    can = m_hit || (fcount != '0);
  end

  always_comb begin
    st          = '0;
    st.cached_a = ma_hit;
    st.match_b  = mb_hit;
    st.ok       = can;
    st.failed   = status;
  end

  function automatic logic [CNT_W-1:0] inc_sat(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount <= NW'(NUM_BUFFERS - 2);
      ebusy <= '0;
      evalid <= NUM_BUFFERS'(5'b00101);
      edly <= NUM_BUFFERS'(5'b00100);
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag[i]   <= TAG_W'(10 * (i + 1));
        order[i] <= (i + 2 < NUM_BUFFERS) ? EW'(i + 2) : '0;
      end
    end else begin
      if (cmd.start) begin
        blk_a <= in_a; blk_b <= in_b; rel <= in_rel;
        status <= 1'b0; hit <= 1'b0; rd <= 1'b0; ahead <= 1'b0;
        waits <= '0; flushes <= '0; idx <= '0;
      end
      if ((cmd.op == OP_TAKE_A) || (cmd.op == OP_TAKE_B && !mb_hit)) begin
        if (!can) begin
          if (cmd.op == OP_TAKE_A) status <= 1'b1;
        end else begin
          if (m_hit && ebusy[sel]) waits <= inc_sat(waits);
          if (!m_hit && edly[sel]) begin
            flushes   <= inc_sat(flushes);
            edly[sel] <= 1'b0;
          end
          ebusy[sel] <= 1'b1;
          if (!m_hit) tag[sel] <= key;
          // Remove sel from the free stack if present.
          if (onlist[sel]) begin
            fcount <= fcount - 1'b1;
            begin
              logic seen;
              seen = 1'b0;
              for (int k = 0; k < NUM_BUFFERS - 1; k++) begin
                if (NW'(k) < fcount && order[k] == sel) seen = 1'b1;
                if (seen) order[k] <= order[k + 1];
              end
            end
          end
          if (cmd.op == OP_TAKE_B) begin
            ahead       <= 1'b1;
            evalid[sel] <= 1'b1;
          end else if (cmd.fin_a) begin
            idx <= IDX_W'(sel);
            if (m_hit && evalid[sel]) hit <= 1'b1;
            else begin
              rd <= 1'b1;
              evalid[sel] <= 1'b1;
            end
          end else begin
            idx <= IDX_W'(sel);
            rd  <= 1'b1;
            evalid[sel] <= 1'b1;
          end
        end
      end
      if (cmd.op == OP_RELEASE && 32'(rel) < NUM_BUFFERS) begin
        if (!onlist[EW'(rel)] && fcount < NW'(NUM_BUFFERS)) begin
          ebusy[EW'(rel)] <= 1'b0;
          order[0] <= EW'(rel);
          for (int k = 1; k < NUM_BUFFERS; k++) order[k] <= order[k - 1];
          fcount <= fcount + 1'b1;
        end
      end
    end
  end

  // Pack: status, index, hit, read, ahead, waits, flushes.
  always_comb begin
    res = '0;
    res[0]   = status;
    res[3:1] = status ? '0 : idx;
    res[4]   = status ? 1'b0 : hit;
    res[5]   = status ? 1'b0 : rd;
    res[6]   = ahead;
    res[8:7] = waits;
    res[10:9] = flushes;
  end
endmodule

// ===== rtl/block_buffer_cache_read_ahead.sv =====
// Top level: buffer cache with read-ahead, stream ports.
// Sequence: the input is taken in idle, then up to two take steps or one release
// step follow (each take step is a tag search and free-stack update), and the
// result register is loaded once the output register is free.
// One request at a time; the next input is taken the cycle after the result
// register is loaded.
// Reset (rst, synchronous): tags 10,20,..., free stack 2..N-1, output empty.
module block_buffer_cache_read_ahead #(
  parameter int NUM_BUFFERS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: func[1:0], block_a[17:2], block_b[33:18], release_index[36:34]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: status, buffer_index[3:1], first_hit, first_read, ahead_read,
  //        wait_count[8:7], flush_count[10:9]
  output logic [15:0] m_tdata
);
  import bbcra_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  busy, done, in_go, out_free;
  logic [15:0] res;

  // Output register frees once taken; controller holds the result until then.
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !busy;
  assign in_go    = s_tvalid && s_tready;

  bbcra_ctrl u_ctrl (
    .clk, .rst, .in_go,
    .func(func_t'(s_tdata[1:0])),
    .st, .out_free, .busy, .done, .cmd
  );

  bbcra_dp #(.NUM_BUFFERS(NUM_BUFFERS)) u_dp (
    .clk, .rst,
    .in_a(s_tdata[17:2]), .in_b(s_tdata[33:18]), .in_rel(s_tdata[36:34]),
    .cmd, .st, .res
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (done) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done) m_tdata <= res;
  end
endmodule
